>>> src/msd_pkg.sv
// Shared types, constants and segment fonts for the segment display controller.
`timescale 1ns / 1ps
`default_nettype none

package msd_pkg;

  // Buffer geometry
  localparam int BUFFER_DEPTH  = 32;
  localparam int TURRET_DIGITS = 4;
  localparam int LED_WORDS     = 1;
  localparam int LED_COUNT     = 8;
  localparam int ADDR_W        = $clog2(BUFFER_DEPTH);
  // scan holds one past the last buffer index before it wraps
  localparam int SCAN_W        = $clog2(BUFFER_DEPTH + 1);
  // wide enough for any region base plus a position, and for any total
  localparam int SUM_W         = 8;

  typedef enum logic [3:0] {
    REQ_TICK       = 4'd0,
    REQ_PUT_UPPER  = 4'd1,
    REQ_PUT_LOWER  = 4'd2,
    REQ_PUT_TURRET = 4'd3,
    REQ_CLR_UPPER  = 4'd4,
    REQ_CLR_LOWER  = 4'd5,
    REQ_CLR_TURRET = 4'd6,
    REQ_LED        = 4'd7,
    REQ_SET_ALL    = 4'd8,
    REQ_CLR_ALL    = 4'd9
  } req_e;

  typedef enum logic [2:0] {
    CFG_UPPER_COUNT  = 3'd0,
    CFG_LOWER_COUNT  = 3'd1,
    CFG_UPPER_FONT   = 3'd2,
    CFG_LOWER_FONT   = 3'd3,
    CFG_LED_MAP_LOW  = 3'd4,
    CFG_LED_MAP_HIGH = 3'd5
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_TICK  = 5'b00010,
    ST_WRAP  = 5'b00100,
    ST_LED   = 5'b01000,
    ST_SWEEP = 5'b10000
  } state_e;

  // Configuration as seen by the controller
  typedef struct packed {
    logic [4:0]  upper_count;
    logic [4:0]  lower_count;
    logic        upper_font;
    logic        lower_font;
    logic [63:0] led_map_low;
    logic [63:0] led_map_high;
  } cfg_t;

  // ASCII range bounds for letters and digits, and the other characters the fonts know
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // Seven-segment bits
  localparam logic [15:0] S7_A = 16'h0001;
  localparam logic [15:0] S7_B = 16'h0002;
  localparam logic [15:0] S7_C = 16'h0004;
  localparam logic [15:0] S7_D = 16'h0008;
  localparam logic [15:0] S7_E = 16'h0010;
  localparam logic [15:0] S7_F = 16'h0020;
  localparam logic [15:0] S7_G = 16'h0040;

  // Sixteen-segment bits
  localparam logic [15:0] S16_A1 = 16'h0001;
  localparam logic [15:0] S16_A2 = 16'h0002;
  localparam logic [15:0] S16_B  = 16'h0004;
  localparam logic [15:0] S16_C  = 16'h0008;
  localparam logic [15:0] S16_D1 = 16'h0010;
  localparam logic [15:0] S16_D2 = 16'h0020;
  localparam logic [15:0] S16_E  = 16'h0040;
  localparam logic [15:0] S16_F  = 16'h0080;
  localparam logic [15:0] S16_G1 = 16'h0100;
  localparam logic [15:0] S16_G2 = 16'h0200;
  localparam logic [15:0] S16_H  = 16'h0400;
  localparam logic [15:0] S16_I  = 16'h0800;
  localparam logic [15:0] S16_J  = 16'h1000;
  localparam logic [15:0] S16_K  = 16'h2000;
  localparam logic [15:0] S16_L  = 16'h4000;
  localparam logic [15:0] S16_M  = 16'h8000;

  localparam logic [15:0] FONT16_DIGIT [10] = '{
    S16_A1|S16_A2|S16_B|S16_C|S16_D1|S16_D2|S16_E|S16_F,
    S16_B|S16_C,
    S16_A1|S16_A2|S16_B|S16_G1|S16_G2|S16_E|S16_D1|S16_D2,
    S16_A1|S16_A2|S16_B|S16_C|S16_D1|S16_D2|S16_G1|S16_G2,
    S16_B|S16_C|S16_G1|S16_G2|S16_F,
    S16_A1|S16_A2|S16_C|S16_D1|S16_D2|S16_F|S16_G1|S16_G2,
    S16_A1|S16_A2|S16_C|S16_D1|S16_D2|S16_E|S16_F|S16_G1|S16_G2,
    S16_A1|S16_A2|S16_B|S16_C,
    S16_A1|S16_A2|S16_B|S16_C|S16_D1|S16_D2|S16_E|S16_F|S16_G1|S16_G2,
    S16_A1|S16_A2|S16_B|S16_C|S16_D1|S16_D2|S16_F|S16_G1|S16_G2
  };

  localparam logic [15:0] FONT16_LETTER [26] = '{
    S16_A1|S16_A2|S16_B|S16_C|S16_E|S16_F|S16_G1|S16_G2,
    S16_A1|S16_A2|S16_B|S16_C|S16_D1|S16_D2|S16_G2|S16_I|S16_L,
    S16_A1|S16_A2|S16_D1|S16_D2|S16_E|S16_F,
    S16_A1|S16_A2|S16_B|S16_C|S16_D1|S16_D2|S16_I|S16_L,
    S16_A1|S16_A2|S16_D1|S16_D2|S16_E|S16_F|S16_G1|S16_G2,
    S16_A1|S16_A2|S16_E|S16_F|S16_G1,
    S16_A1|S16_A2|S16_C|S16_D1|S16_D2|S16_E|S16_F|S16_G2,
    S16_B|S16_C|S16_E|S16_F|S16_G1|S16_G2,
    S16_A1|S16_A2|S16_I|S16_L|S16_D1|S16_D2,
    S16_B|S16_C|S16_D1|S16_D2|S16_E,
    S16_E|S16_F|S16_G1|S16_J|S16_K,
    S16_D1|S16_D2|S16_E|S16_F,
    S16_B|S16_C|S16_E|S16_F|S16_H|S16_J,
    S16_B|S16_C|S16_E|S16_F|S16_H|S16_K,
    S16_A1|S16_A2|S16_B|S16_C|S16_D1|S16_D2|S16_E|S16_F,
    S16_A1|S16_A2|S16_B|S16_E|S16_F|S16_G1|S16_G2,
    S16_A1|S16_A2|S16_B|S16_C|S16_D1|S16_D2|S16_E|S16_F|S16_K,
    S16_A1|S16_A2|S16_B|S16_E|S16_F|S16_G1|S16_G2|S16_K,
    S16_A1|S16_A2|S16_C|S16_D1|S16_D2|S16_F|S16_G1|S16_G2,
    S16_A1|S16_A2|S16_I|S16_L,
    S16_B|S16_C|S16_D1|S16_D2|S16_E|S16_F,
    S16_E|S16_F|S16_J|S16_M,
    S16_B|S16_C|S16_E|S16_F|S16_K|S16_M,
    S16_H|S16_J|S16_K|S16_M,
    S16_H|S16_J|S16_L,
    S16_A1|S16_A2|S16_D1|S16_D2|S16_J|S16_M
  };

  localparam logic [15:0] FONT7_DIGIT [10] = '{
    S7_A|S7_B|S7_C|S7_D|S7_E|S7_F,
    S7_B|S7_C,
    S7_A|S7_B|S7_D|S7_E|S7_G,
    S7_A|S7_B|S7_C|S7_D|S7_G,
    S7_B|S7_C|S7_F|S7_G,
    S7_A|S7_C|S7_D|S7_F|S7_G,
    S7_A|S7_C|S7_D|S7_E|S7_F|S7_G,
    S7_A|S7_B|S7_C,
    S7_A|S7_B|S7_C|S7_D|S7_E|S7_F|S7_G,
    S7_A|S7_B|S7_C|S7_D|S7_F|S7_G
  };

  localparam logic [15:0] FONT7_LETTER [26] = '{
    S7_A|S7_B|S7_C|S7_E|S7_F|S7_G,
    S7_C|S7_D|S7_E|S7_F|S7_G,
    S7_A|S7_D|S7_E|S7_F,
    S7_B|S7_C|S7_D|S7_E|S7_G,
    S7_A|S7_D|S7_E|S7_F|S7_G,
    S7_A|S7_E|S7_F|S7_G,
    S7_A|S7_C|S7_D|S7_E|S7_F,
    S7_B|S7_C|S7_E|S7_F|S7_G,
    S7_B|S7_C,
    S7_B|S7_C|S7_D|S7_E,
    S7_B|S7_E|S7_F|S7_G,
    S7_D|S7_E|S7_F,
    S7_A|S7_C|S7_E|S7_G,
    S7_C|S7_E|S7_G,
    S7_A|S7_B|S7_C|S7_D|S7_E|S7_F,
    S7_A|S7_B|S7_E|S7_F|S7_G,
    S7_A|S7_B|S7_C|S7_F|S7_G,
    S7_E|S7_G,
    S7_A|S7_C|S7_D|S7_F|S7_G,
    S7_D|S7_E|S7_F|S7_G,
    S7_B|S7_C|S7_D|S7_E|S7_F,
    S7_C|S7_D|S7_E,
    S7_A|S7_D|S7_G,
    S7_A|S7_D|S7_G,
    S7_B|S7_C|S7_D|S7_F|S7_G,
    S7_D|S7_G
  };

  // Sixteen-segment encoding; letters fold to upper case, unknown is blank
  function automatic logic [15:0] enc16(input logic [7:0] c);
    logic [7:0]  k;
    logic [15:0] w;
    k = '0;
    w = '0;
    if (c >= CH_UC_A && c <= CH_UC_Z) begin
      k = c - CH_UC_A;
      w = FONT16_LETTER[k[4:0]];
    end else if (c >= CH_LC_A && c <= CH_LC_Z) begin
      k = c - CH_LC_A;
      w = FONT16_LETTER[k[4:0]];
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      k = c - CH_ZERO;
      w = FONT16_DIGIT[k[3:0]];
    end else if (c == CH_MINUS) begin
      w = S16_G1 | S16_G2;
    end else if (c == CH_PLUS) begin
      w = S16_G1 | S16_G2 | S16_I | S16_L;
    end else if (c == CH_LT) begin
      w = S16_J | S16_K;
    end else if (c == CH_GT) begin
      w = S16_H | S16_M;
    end else if (c == CH_SLASH) begin
      w = S16_J | S16_M;
    end
    return w;
  endfunction

  // Seven-segment encoding, same folding rules
  function automatic logic [15:0] enc7(input logic [7:0] c);
    logic [7:0]  k;
    logic [15:0] w;
    k = '0;
    w = '0;
    if (c >= CH_UC_A && c <= CH_UC_Z) begin
      k = c - CH_UC_A;
      w = FONT7_LETTER[k[4:0]];
    end else if (c >= CH_LC_A && c <= CH_LC_Z) begin
      k = c - CH_LC_A;
      w = FONT7_LETTER[k[4:0]];
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      k = c - CH_ZERO;
      w = FONT7_DIGIT[k[3:0]];
    end else if (c == CH_MINUS) begin
      w = S7_G;
    end else if (c == CH_UNDER) begin
      w = S7_D;
    end
    return w;
  endfunction

endpackage

`default_nettype wire

>>> src/msd_ram.sv
// Simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module msd_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/msd_ctrl.sv
// Request sequencer: puts, region sweeps, LED read-modify-write and refresh scan.
`timescale 1ns / 1ps
`default_nettype none

module msd_ctrl
  import msd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  // item in
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [3:0]  req_type_i,
  input  wire logic [4:0]  position_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [2:0]  led_index_i,
  input  wire logic        led_on_i,
  // result out
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [4:0]       digit_index_o,
  output logic [15:0]      segment_word_o
);

  state_e state_q, state_d;

  // buffer port signals
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [15:0]       wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [15:0]       rd_data;

  // entry valid bits: an unwritten entry reads as zero
  logic [BUFFER_DEPTH-1:0] vld_q, vld_d;
  logic                    rd_vld_q;
  logic [15:0]             rd_word;

  logic [SCAN_W-1:0] scan_q, scan_d;
  logic [SUM_W-1:0]  sw_addr_q, sw_addr_d;
  logic [SUM_W-1:0]  sw_left_q, sw_left_d;
  logic [15:0]       sw_fill_q, sw_fill_d;
  logic [ADDR_W-1:0] led_addr_q, led_addr_d;
  logic [15:0]       led_map_q, led_map_d;
  logic              led_on_q, led_on_d;

  logic              out_valid_q, out_valid_d;
  logic [4:0]        out_idx_q, out_idx_d;
  logic [15:0]       out_word_q, out_word_d;

  logic              in_accept;
  logic              out_free;
  logic              out_load;
  req_e              req;

  // region geometry
  logic [SUM_W-1:0] upper_n, lower_n, lower_base, led_base, turret_base;
  logic [SUM_W-1:0] total_raw, total;
  logic [SUM_W-1:0] pos_ext;
  logic [SUM_W-1:0] put_addr;
  logic             put_ok;
  logic [15:0]      put_word;
  logic [63:0]      led_src;

  assign upper_n     = SUM_W'(cfg_i.upper_count);
  assign lower_n     = SUM_W'(cfg_i.lower_count);
  assign lower_base  = upper_n;
  assign led_base    = upper_n + lower_n;
  assign turret_base = led_base + SUM_W'(LED_WORDS);
  assign total_raw   = turret_base + SUM_W'(TURRET_DIGITS);
  assign total       = (total_raw > SUM_W'(BUFFER_DEPTH)) ? SUM_W'(BUFFER_DEPTH) : total_raw;
  assign pos_ext     = SUM_W'(position_i);

  assign req        = req_e'(req_type_i);
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign rd_word    = rd_vld_q ? rd_data : 16'h0000;
  assign led_src    = led_index_i[2] ? cfg_i.led_map_high : cfg_i.led_map_low;

  // put address and encoded word
  always_comb begin
    put_addr = pos_ext;
    put_ok   = 1'b0;
    put_word = 16'h0000;
    case (req)
      REQ_PUT_UPPER: begin
        put_addr = pos_ext;
        put_ok   = pos_ext < upper_n;
        put_word = cfg_i.upper_font ? enc16(char_code_i) : enc7(char_code_i);
      end
      REQ_PUT_LOWER: begin
        put_addr = lower_base + pos_ext;
        put_ok   = pos_ext < lower_n;
        put_word = cfg_i.lower_font ? enc16(char_code_i) : enc7(char_code_i);
      end
      REQ_PUT_TURRET: begin
        put_addr = turret_base + pos_ext;
        put_ok   = pos_ext < SUM_W'(TURRET_DIGITS);
        put_word = enc7(char_code_i);
      end
      default: begin
        put_ok = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    sw_addr_d   = sw_addr_q;
    sw_left_d   = sw_left_q;
    sw_fill_d   = sw_fill_q;
    led_addr_d  = led_addr_q;
    led_map_d   = led_map_q;
    led_on_d    = led_on_q;
    vld_d       = vld_q;
    wr_en       = 1'b0;
    wr_addr     = put_addr[ADDR_W-1:0];
    wr_data     = put_word;
    rd_en       = 1'b0;
    rd_addr     = scan_q[ADDR_W-1:0];
    out_load    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_idx_d   = out_idx_q;
    out_word_d  = out_word_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (req)
            REQ_TICK: begin
              rd_en   = 1'b1;
              rd_addr = scan_q[ADDR_W-1:0];
              state_d = ST_TICK;
            end
            REQ_PUT_UPPER, REQ_PUT_LOWER, REQ_PUT_TURRET: begin
              wr_en = put_ok && (put_addr < SUM_W'(BUFFER_DEPTH));
            end
            REQ_CLR_UPPER: begin
              sw_addr_d = '0;
              sw_left_d = upper_n;
              sw_fill_d = 16'h0000;
              if (upper_n != '0) state_d = ST_SWEEP;
            end
            REQ_CLR_LOWER: begin
              sw_addr_d = lower_base;
              sw_left_d = lower_n;
              sw_fill_d = 16'h0000;
              if (lower_n != '0) state_d = ST_SWEEP;
            end
            REQ_CLR_TURRET: begin
              sw_addr_d = turret_base;
              sw_left_d = SUM_W'(TURRET_DIGITS);
              sw_fill_d = 16'h0000;
              if (TURRET_DIGITS != 0) state_d = ST_SWEEP;
            end
            REQ_LED: begin
              if ((4'(led_index_i) < 4'(LED_COUNT)) &&
                  (led_base < SUM_W'(BUFFER_DEPTH))) begin
                rd_en      = 1'b1;
                rd_addr    = led_base[ADDR_W-1:0];
                led_addr_d = led_base[ADDR_W-1:0];
                led_map_d  = led_src[16*led_index_i[1:0] +: 16];
                led_on_d   = led_on_i;
                state_d    = ST_LED;
              end
            end
            REQ_SET_ALL: begin
              sw_addr_d = '0;
              sw_left_d = SUM_W'(BUFFER_DEPTH);
              sw_fill_d = 16'hFFFF;
              state_d   = ST_SWEEP;
            end
            REQ_CLR_ALL: begin
              vld_d = '0;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_TICK: begin
        // hand the word to the output register once it is free
        if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          out_idx_d   = 5'(scan_q);
          out_word_d  = rd_word;
          scan_d      = scan_q + SCAN_W'(1);
          state_d     = ST_WRAP;
        end
      end
      ST_WRAP: begin
        // reduce modulo the total, one subtraction a cycle
        if (SUM_W'(scan_q) >= total) begin
          scan_d = SCAN_W'(SUM_W'(scan_q) - total);
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_LED: begin
        wr_en   = 1'b1;
        wr_addr = led_addr_q;
        wr_data = led_on_q ? (rd_word | led_map_q) : (rd_word & ~led_map_q);
        state_d = ST_IDLE;
      end
      ST_SWEEP: begin
        wr_en     = sw_addr_q < SUM_W'(BUFFER_DEPTH);
        wr_addr   = sw_addr_q[ADDR_W-1:0];
        wr_data   = sw_fill_q;
        sw_addr_d = sw_addr_q + SUM_W'(1);
        sw_left_d = sw_left_q - SUM_W'(1);
        if (sw_left_q == SUM_W'(1)) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (wr_en) vld_d[wr_addr] = 1'b1;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_q      <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
      sw_left_q   <= '0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
      sw_left_q   <= sw_left_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sw_addr_q  <= sw_addr_d;
    sw_fill_q  <= sw_fill_d;
    led_addr_q <= led_addr_d;
    led_map_q  <= led_map_d;
    led_on_q   <= led_on_d;
    out_idx_q  <= out_idx_d;
    out_word_q <= out_word_d;
    if (rd_en) rd_vld_q <= vld_q[rd_addr];
  end

  msd_ram #(
    .DEPTH (BUFFER_DEPTH),
    .WIDTH (16)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign out_valid_o    = out_valid_q;
  assign digit_index_o  = out_idx_q;
  assign segment_word_o = out_word_q;

  // checks
  a_scan_in_buffer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (SUM_W'(scan_q) < SUM_W'(BUFFER_DEPTH)))
    else $error("scan position outside buffer while idle");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_TICK) || (state_q == ST_WRAP)) |-> !wr_en)
    else $error("buffer written during refresh scan");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten while held");

  a_tick_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (req == REQ_TICK)) |=> (state_q == ST_TICK))
    else $error("tick item did not enter scan read");

endmodule

`default_nettype wire

>>> src/multiplexed_segment_display_controller_core.sv
// Top level of the segment display controller: configuration registers and sequencer.
// A tick item's word comes through the buffer's registered read port into the result register
// once the output is free. The input stalls until an item is done: puts and clear-all leave
// the block idle; LED items read the entry, then write it back; ticks then wrap the scan
// position, one subtraction a cycle; region clears and set-all write one buffer entry a cycle.
// Reset: asynchronous, active low; per-entry valid bits make the buffer read as zero at
// once, with no clearing pass; configuration returns to 5, 4, 1, 0, 0, 0.
`timescale 1ns / 1ps
`default_nettype none

module multiplexed_segment_display_controller_core
  import msd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  // items in
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [3:0]  req_type_i,
  input  wire logic [4:0]  position_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [2:0]  led_index_i,
  input  wire logic        led_on_i,
  // results out
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [4:0]       digit_index_o,
  output logic [15:0]      segment_word_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_UPPER_COUNT:  cfg_d.upper_count  = cfg_data_i[4:0];
        CFG_LOWER_COUNT:  cfg_d.lower_count  = cfg_data_i[4:0];
        CFG_UPPER_FONT:   cfg_d.upper_font   = cfg_data_i[0];
        CFG_LOWER_FONT:   cfg_d.lower_font   = cfg_data_i[0];
        CFG_LED_MAP_LOW:  cfg_d.led_map_low  = cfg_data_i;
        CFG_LED_MAP_HIGH: cfg_d.led_map_high = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.upper_count  <= 5'd5;
      cfg_q.lower_count  <= 5'd4;
      cfg_q.upper_font   <= 1'b1;
      cfg_q.lower_font   <= 1'b0;
      cfg_q.led_map_low  <= '0;
      cfg_q.led_map_high <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  msd_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .position_i     (position_i),
    .char_code_i    (char_code_i),
    .led_index_i    (led_index_i),
    .led_on_i       (led_on_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .digit_index_o  (digit_index_o),
    .segment_word_o (segment_word_o)
  );

endmodule

`default_nettype wire

>>> sim/msd_scan_checker.sv
// Scoreboard for the segment display controller: shadow buffer, scan prediction and result checks.
`timescale 1ns / 1ps

module msd_scan_checker
  import msd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [3:0]  req_type_i,
  input  logic [4:0]  position_i,
  input  logic [7:0]  char_code_i,
  input  logic [2:0]  led_index_i,
  input  logic        led_on_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [4:0]  digit_index_i,
  input  logic [15:0] segment_word_i,
  output int          fail_count_o,
  output int          scans_due_o,
  output int          scans_seen_o
);

  // one refresh read the block owes us
  typedef struct packed {
    logic [4:0]  digit;
    logic [15:0] word;
  } scan_read_t;

  // sixteen-segment glyphs, A to Z then 0 to 9
  localparam logic [15:0] SEG16_ALPHA [26] = '{
    16'h03CF, 16'h4A3F, 16'h00F3, 16'h483F, 16'h03F3, 16'h01C3, 16'h02FB,
    16'h03CC, 16'h4833, 16'h007C, 16'h31C0, 16'h00F0, 16'h14CC, 16'h24CC,
    16'h00FF, 16'h03C7, 16'h20FF, 16'h23C7, 16'h03BB, 16'h4803, 16'h00FC,
    16'h90C0, 16'hA0CC, 16'hB400, 16'h5400, 16'h9033
  };
  localparam logic [15:0] SEG16_NUM [10] = '{
    16'h00FF, 16'h000C, 16'h0377, 16'h033F, 16'h038C,
    16'h03BB, 16'h03FB, 16'h000F, 16'h03FF, 16'h03BF
  };

  // seven-segment glyphs
  localparam logic [15:0] SEG7_ALPHA [26] = '{
    16'h0077, 16'h007C, 16'h0039, 16'h005E, 16'h0079, 16'h0071, 16'h003D,
    16'h0076, 16'h0006, 16'h001E, 16'h0072, 16'h0038, 16'h0055, 16'h0054,
    16'h003F, 16'h0073, 16'h0067, 16'h0050, 16'h006D, 16'h0078, 16'h003E,
    16'h001C, 16'h0049, 16'h0049, 16'h006E, 16'h0048
  };
  localparam logic [15:0] SEG7_NUM [10] = '{
    16'h003F, 16'h0006, 16'h005B, 16'h004F, 16'h0066,
    16'h006D, 16'h007D, 16'h0007, 16'h007F, 16'h006F
  };

  // shadow of the block's state and registers
  logic [15:0] shadow_buf [BUFFER_DEPTH];
  logic [4:0]  scan_at;
  logic [4:0]  n_upper;
  logic [4:0]  n_lower;
  logic        wide_upper;
  logic        wide_lower;
  logic [63:0] map_lo;
  logic [63:0] map_hi;

  scan_read_t  scan_reads_due [$];
  scan_read_t  want;
  int          fails;
  int          seen;

  // fold lower case onto upper case
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
  endfunction

  function automatic logic [15:0] glyph16(input logic [7:0] c);
    logic [7:0] up;
    up = fold_case(c);
    if (up >= 8'h41 && up <= 8'h5A) return SEG16_ALPHA[up - 8'h41];
    if (up >= 8'h30 && up <= 8'h39) return SEG16_NUM[up - 8'h30];
    case (up)
      8'h2D:   return 16'h0300;  // minus
      8'h2B:   return 16'h4B00;  // plus
      8'h3C:   return 16'h3000;  // less-than
      8'h3E:   return 16'h8400;  // greater-than
      8'h2F:   return 16'h9000;  // slash
      default: return 16'h0000;
    endcase
  endfunction

  function automatic logic [15:0] glyph7(input logic [7:0] c);
    logic [7:0] up;
    up = fold_case(c);
    if (up >= 8'h41 && up <= 8'h5A) return SEG7_ALPHA[up - 8'h41];
    if (up >= 8'h30 && up <= 8'h39) return SEG7_NUM[up - 8'h30];
    case (up)
      8'h2D:   return 16'h0040;  // minus
      8'h5F:   return 16'h0008;  // underscore
      default: return 16'h0000;
    endcase
  endfunction

  // writes past the buffer end are dropped
  task automatic store_word(input int idx, input logic [15:0] w);
    if (idx < BUFFER_DEPTH) shadow_buf[idx] = w;
  endtask

  task automatic clear_span(input int base, input int size);
    for (int k = 0; k < size; k++) store_word(base + k, 16'h0000);
  endtask

  // apply one accepted item to the shadow state
  task automatic predict_display_item(input logic [3:0] req, input logic [4:0] pos,
                                      input logic [7:0] ch, input logic [2:0] led,
                                      input logic on);
    int          lower_base;
    int          led_base;
    int          turret_base;
    int          total;
    logic [63:0] src;
    logic [15:0] bitmap;
    scan_read_t  rd;
    lower_base  = n_upper;
    led_base    = n_upper + n_lower;
    turret_base = led_base + LED_WORDS;
    case (req)
      REQ_TICK: begin
        total = turret_base + TURRET_DIGITS;
        if (total > BUFFER_DEPTH) total = BUFFER_DEPTH;
        rd.digit = scan_at;
        rd.word  = shadow_buf[scan_at];
        scan_reads_due.push_back(rd);
        // a scan left beyond a shrunk total still wraps on its next step
        scan_at = 5'((int'(scan_at) + 1) % total);
      end
      REQ_PUT_UPPER: begin
        if (pos < n_upper) store_word(pos, wide_upper ? glyph16(ch) : glyph7(ch));
      end
      REQ_PUT_LOWER: begin
        if (pos < n_lower)
          store_word(lower_base + pos, wide_lower ? glyph16(ch) : glyph7(ch));
      end
      REQ_PUT_TURRET: begin
        if (pos < TURRET_DIGITS) store_word(turret_base + pos, glyph7(ch));
      end
      REQ_CLR_UPPER:  clear_span(0, n_upper);
      REQ_CLR_LOWER:  clear_span(lower_base, n_lower);
      REQ_CLR_TURRET: clear_span(turret_base, TURRET_DIGITS);
      REQ_LED: begin
        if (int'(led) < LED_COUNT && led_base < BUFFER_DEPTH) begin
          src    = led[2] ? map_hi : map_lo;
          bitmap = src[led[1:0]*16 +: 16];
          if (on) shadow_buf[led_base] = shadow_buf[led_base] | bitmap;
          else    shadow_buf[led_base] = shadow_buf[led_base] & ~bitmap;
        end
      end
      REQ_SET_ALL: begin
        for (int k = 0; k < BUFFER_DEPTH; k++) shadow_buf[k] = 16'hFFFF;
      end
      REQ_CLR_ALL: begin
        for (int k = 0; k < BUFFER_DEPTH; k++) shadow_buf[k] = 16'h0000;
      end
      default: ;  // unused codes leave everything alone
    endcase
  endtask

  // watch all three channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < BUFFER_DEPTH; k++) shadow_buf[k] = 16'h0000;
      scan_at    = '0;
      n_upper    = 5'd5;
      n_lower    = 5'd4;
      wide_upper = 1'b1;
      wide_lower = 1'b0;
      map_lo     = '0;
      map_hi     = '0;
      scan_reads_due.delete();
      fails = 0;
      seen  = 0;
    end else begin
      // results first: an item accepted now cannot already have its result out
      if (out_valid_i && !out_stall_i) begin
        if (scan_reads_due.size() == 0) begin
          $error("unexpected result: digit_index %0d segment_word %04h",
                 digit_index_i, segment_word_i);
          fails++;
        end else begin
          want = scan_reads_due.pop_front();
          seen++;
          if (digit_index_i !== want.digit) begin
            $error("digit_index: expected %0d, actual %0d", want.digit, digit_index_i);
            fails++;
          end
          if (segment_word_i !== want.word) begin
            $error("segment_word: expected %04h, actual %04h", want.word, segment_word_i);
            fails++;
          end
        end
      end
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_UPPER_COUNT:  n_upper    = cfg_data_i[4:0];
          CFG_LOWER_COUNT:  n_lower    = cfg_data_i[4:0];
          CFG_UPPER_FONT:   wide_upper = cfg_data_i[0];
          CFG_LOWER_FONT:   wide_lower = cfg_data_i[0];
          CFG_LED_MAP_LOW:  map_lo     = cfg_data_i;
          CFG_LED_MAP_HIGH: map_hi     = cfg_data_i;
          default: ;
        endcase
      end
      // items
      if (in_valid_i && !in_stall_i)
        predict_display_item(req_type_i, position_i, char_code_i, led_index_i, led_on_i);
    end
    fail_count_o <= fails;
    scans_due_o  <= scan_reads_due.size();
    scans_seen_o <= seen;
  end

endmodule

>>> sim/tb_top.sv
// Testbench top for the segment display controller: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_top;
  import msd_pkg::*;

  localparam int SETTLE_CYCLES = 48;   // longest item (set all) plus margin
  localparam int HOLD_CYCLES   = 300;  // long receiver hold-off
  localparam int PHASE_ITEMS   = 46;
  localparam int SQUEEZE_TICKS = 40;

  // request codes the block does not use
  localparam logic [3:0] REQ_UNUSED_LO = 4'd10;
  localparam logic [3:0] REQ_UNUSED_HI = 4'd15;

  // punctuation the fonts know
  localparam logic [7:0] PUNCT [6] = '{8'h2D, 8'h2B, 8'h3C, 8'h3E, 8'h2F, 8'h5F};

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_reg_e    cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  req_type;
  logic [4:0]  position;
  logic [7:0]  char_code;
  logic [2:0]  led_index;
  logic        led_on;
  logic        out_valid;
  logic        out_stall;
  logic [4:0]  digit_index;
  logic [15:0] segment_word;

  int          fail_count;
  int          scans_due;
  int          scans_seen;
  int          items_sent = 0;
  int          cfg_writes = 0;
  bit          calm = 1'b0;         // no idling on either side
  bit          squeeze_req = 1'b0;  // asks the receiver for its long hold-off
  bit          steady = 1'b0;       // sender offers back to back

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  multiplexed_segment_display_controller_core u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .req_type_i     (req_type),
    .position_i     (position),
    .char_code_i    (char_code),
    .led_index_i    (led_index),
    .led_on_i       (led_on),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .digit_index_o  (digit_index),
    .segment_word_o (segment_word)
  );

  msd_scan_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .req_type_i     (req_type),
    .position_i     (position),
    .char_code_i    (char_code),
    .led_index_i    (led_index),
    .led_on_i       (led_on),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .digit_index_i  (digit_index),
    .segment_word_i (segment_word),
    .fail_count_o   (fail_count),
    .scans_due_o    (scans_due),
    .scans_seen_o   (scans_seen)
  );

  // offer one item, with an optional gap in front, and wait for it to go in
  task automatic offer_item(input logic [3:0] req, input logic [4:0] pos,
                            input logic [7:0] ch, input logic [2:0] led, input logic on);
    int gap;
    if (!calm && !steady && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid  <= 1'b0;
      req_type  <= 4'($urandom);
      position  <= 5'($urandom);
      char_code <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
    req_type  <= req;
    position  <= pos;
    char_code <= ch;
    led_index <= led;
    led_on    <= on;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // stop offering, wait for every result, then let slow items finish
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (scans_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  task automatic load_setting(input logic [4:0] up, input logic [4:0] lo,
                              input logic font_up, input logic font_lo,
                              input logic [63:0] map_lo, input logic [63:0] map_hi);
    write_reg(CFG_UPPER_COUNT, 64'(up));
    write_reg(CFG_LOWER_COUNT, 64'(lo));
    write_reg(CFG_UPPER_FONT, 64'(font_up));
    write_reg(CFG_LOWER_FONT, 64'(font_lo));
    write_reg(CFG_LED_MAP_LOW, map_lo);
    write_reg(CFG_LED_MAP_HIGH, map_hi);
  endtask

  // mostly ticks and puts with random content, some clears, LEDs and junk codes
  task automatic offer_random_item();
    int         pick;
    logic [3:0] req;
    logic [4:0] pos;
    logic [7:0] ch;
    pick = $urandom_range(0, 99);
    pos  = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 16));
    case ($urandom_range(0, 5))
      0:       ch = 8'h41 + 8'($urandom_range(0, 25));
      1:       ch = 8'h61 + 8'($urandom_range(0, 25));
      2:       ch = 8'h30 + 8'($urandom_range(0, 9));
      3:       ch = PUNCT[$urandom_range(0, 5)];
      default: ch = 8'($urandom_range(0, 255));
    endcase
    if (pick < 40)      req = REQ_TICK;
    else if (pick < 52) req = REQ_PUT_UPPER;
    else if (pick < 62) req = REQ_PUT_LOWER;
    else if (pick < 70) begin
      req = REQ_PUT_TURRET;
      pos = 5'($urandom_range(0, 5));
    end
    else if (pick < 80) req = REQ_LED;
    else if (pick < 84) req = 4'($urandom_range(REQ_CLR_UPPER, REQ_CLR_TURRET));
    else if (pick < 86) req = REQ_SET_ALL;
    else if (pick < 89) req = REQ_CLR_ALL;
    else if (pick < 92) req = 4'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
    else begin
      req = 4'($urandom_range(REQ_PUT_UPPER, REQ_PUT_TURRET));
      pos = 5'($urandom_range(0, 31));
    end
    offer_item(req, pos, ch, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
  endtask

  // receiver: random stall bursts, one long hold-off on request, none once calm
  initial begin
    int n;
    bit v;
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    wait (rst_n == 1'b1);
    @(posedge clk);
    forever begin
      if (squeeze_req && !held) begin
        held = 1'b1;
        v = 1'b1;
        n = HOLD_CYCLES;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        v = 1'b1;
        n = $urandom_range(1, 17);
      end else begin
        v = 1'b0;
        n = calm ? 1 : $urandom_range(1, 24);
      end
      out_stall <= v;
      repeat (n) @(posedge clk);
    end
  end

  // stimulus and verdict
  initial begin
    cfg_valid <= 1'b0;
    cfg_index <= CFG_UPPER_COUNT;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    req_type  <= REQ_TICK;
    position  <= '0;
    char_code <= '0;
    led_index <= '0;
    led_on    <= 1'b0;
    wait (rst_n == 1'b1);
    @(posedge clk);

    // directed: puts at region edges, odd characters, unused codes, ticks around set-all and clears (reset setting)
    offer_item(REQ_PUT_UPPER, 5'd0, 8'h41, 3'd0, 1'b0);   // 'A', wide font
    offer_item(REQ_PUT_UPPER, 5'd4, 8'h7A, 3'd0, 1'b0);   // 'z', last upper digit
    offer_item(REQ_PUT_UPPER, 5'd5, 8'h38, 3'd0, 1'b0);   // just past the region
    offer_item(REQ_PUT_UPPER, 5'd1, 8'hFF, 3'd0, 1'b0);   // unknown character
    offer_item(REQ_PUT_LOWER, 5'd0, 8'h39, 3'd0, 1'b0);   // '9', narrow font
    offer_item(REQ_PUT_LOWER, 5'd3, 8'h5F, 3'd0, 1'b0);   // underscore
    offer_item(REQ_PUT_LOWER, 5'd4, 8'h57, 3'd0, 1'b0);   // past the region
    offer_item(REQ_PUT_TURRET, 5'd0, 8'h2D, 3'd0, 1'b0);  // minus
    offer_item(REQ_PUT_TURRET, 5'd3, 8'h62, 3'd0, 1'b0);  // 'b'
    offer_item(REQ_PUT_TURRET, 5'd4, 8'h31, 3'd0, 1'b0);  // past the turret
    offer_item(REQ_UNUSED_LO, 5'd0, 8'h00, 3'd0, 1'b0);
    offer_item(REQ_UNUSED_HI, 5'd31, 8'hFF, 3'd7, 1'b1);
    offer_item(REQ_TICK, 5'd0, 8'h00, 3'd0, 1'b0);
    offer_item(REQ_TICK, 5'd31, 8'hFF, 3'd7, 1'b1);
    offer_item(REQ_SET_ALL, 5'd0, 8'h00, 3'd0, 1'b0);
    offer_item(REQ_TICK, 5'd0, 8'h00, 3'd0, 1'b0);
    offer_item(REQ_CLR_UPPER, 5'd0, 8'h00, 3'd0, 1'b0);
    offer_item(REQ_TICK, 5'd0, 8'h00, 3'd0, 1'b0);
    offer_item(REQ_CLR_ALL, 5'd0, 8'h00, 3'd0, 1'b0);
    offer_item(REQ_TICK, 5'd0, 8'h00, 3'd0, 1'b0);
    drain_and_settle();

    // directed: LED bitmaps from both map words, region clears
    load_setting(5'd5, 5'd4, 1'b1, 1'b0, 64'h8001_00FF_F0F0_1234, 64'hFFFF_0000_5A5A_C3C3);
    offer_item(REQ_LED, 5'd0, 8'h00, 3'd0, 1'b1);
    offer_item(REQ_LED, 5'd0, 8'h00, 3'd7, 1'b1);
    offer_item(REQ_LED, 5'd0, 8'h00, 3'd4, 1'b0);
    offer_item(REQ_CLR_LOWER, 5'd0, 8'h00, 3'd0, 1'b0);
    offer_item(REQ_CLR_TURRET, 5'd0, 8'h00, 3'd0, 1'b0);

    // random phases, each under its own register setting
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: ;  // keep the LED setting above
        1: load_setting(5'd0, 5'd0, 1'b0, 1'b1, {$urandom, $urandom}, {$urandom, $urandom});
        2: load_setting(5'd16, 5'd16, 1'b1, 1'b1, '1, '1);
        3: load_setting(5'd16, 5'd0, 1'b0, 1'b0, {$urandom, $urandom}, {$urandom, $urandom});
        4: load_setting(5'd0, 5'd16, 1'b1, 1'b0, '0, '0);
        default: load_setting(5'($urandom_range(0, 16)), 5'($urandom_range(0, 16)),
                              1'($urandom), 1'($urandom),
                              {$urandom, $urandom}, {$urandom, $urandom});
      endcase
      if (ph == 3) begin
        // fill the block while the receiver holds off
        squeeze_req <= 1'b1;
        steady = 1'b1;
        repeat (SQUEEZE_TICKS)
          offer_item(REQ_TICK, 5'($urandom), 8'($urandom), 3'($urandom), 1'($urandom));
        steady = 1'b0;
      end
      if (ph == 7) calm <= 1'b1;
      repeat (PHASE_ITEMS) offer_random_item();
      drain_and_settle();
    end

    $display("covered %0d items under %0d register writes across 9 settings",
             items_sent, cfg_writes);
    $display("compared %0d scan results, including one long output hold-off", scans_seen);
    if (fail_count == 0 && scans_due == 0) begin
      $display("multiplexed_segment_display_controller_core verification clean");
    end else begin
      $display("multiplexed_segment_display_controller_core verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("multiplexed_segment_display_controller_core verification failed");
    $finish;
  end

endmodule
